>>> hw/rtl/gqi_pkg.sv
package gqi_pkg;

    localparam int QUAT_FRAC_BITS = 30;
    localparam int ANG_FRAC       = 30;
    localparam int CORDIC_STEPS   = 30;

    // register indexes on the configuration port
    localparam logic [2:0] REG_HALF_STEP = 3'd0;
    localparam logic [2:0] REG_START_W   = 3'd1;
    localparam logic [2:0] REG_START_X   = 3'd2;
    localparam logic [2:0] REG_START_Y   = 3'd3;
    localparam logic [2:0] REG_START_Z   = 3'd4;

    localparam logic [31:0]        HALF_STEP_RESET = 32'd10737418;
    localparam logic signed [31:0] QUAT_ONE        = 32'(64'd1 << QUAT_FRAC_BITS);
    localparam logic [37:0]        ANG_ONE         = 38'(64'd1 << ANG_FRAC);
    localparam logic [37:0]        SMALL_ANGLE     = 38'd1073;
    localparam logic [37:0]        TWO_PI_Q        = 38'd6746518852;
    localparam logic [37:0]        PI_Q            = 38'd3373259426;
    localparam logic [37:0]        HALF_PI_Q       = 38'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032874;

    typedef struct packed {
        logic [31:0]        half_step;
        logic signed [31:0] start_w;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic        start;
        logic [61:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } result_t;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            5'd24: r = 34'sd64;
            5'd25: r = 34'sd32;
            5'd26: r = 34'sd16;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Hamilton product: term (j,k) is q[k] * s[j^k]; these ones subtract
    function automatic logic ham_neg(input logic [1:0] j, input logic [1:0] k);
        logic n;
        n = ((j == 2'd0) && (k != 2'd0)) ||
            ((j == 2'd1) && (k == 2'd3)) ||
            ((j == 2'd2) && (k == 2'd1)) ||
            ((j == 2'd3) && (k == 2'd2));
        return n;
    endfunction

endpackage

>>> hw/rtl/gqi_ifs.sv
interface gqi_sample_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
    logic               first_sample;
    modport source(output valid, rate_x, rate_y, rate_z, first_sample, input ready);
    modport sink(input valid, rate_x, rate_y, rate_z, first_sample, output ready);
endinterface

interface gqi_orient_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] orient_w;
    logic signed [31:0] orient_x;
    logic signed [31:0] orient_y;
    logic signed [31:0] orient_z;
    modport source(output valid, orient_w, orient_x, orient_y, orient_z, input ready);
    modport sink(input valid, orient_w, orient_x, orient_y, orient_z, output ready);
endinterface

interface gqi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/gqi_isqrt.sv
module gqi_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  gqi_pkg::sqrt_req_t req,
    output gqi_pkg::sqrt_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [64:0] trial;

    assign trial = 65'(res_reg) + 65'(bit_reg);

    // one result bit per cycle
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            x_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                x_reg    <= req.radicand;
                res_reg  <= '0;
                bit_reg  <= 64'd1 << 62;
            end
            else if (busy_reg) begin
                if ({1'b0, x_reg} >= trial) begin
                    x_reg   <= 64'({1'b0, x_reg} - trial);
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

endmodule

>>> hw/rtl/gqi_div.sv
module gqi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gqi_pkg::div_req_t req,
    output gqi_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [61:0] rem_reg;
    logic [62:0] dsh_reg;
    logic [31:0] q_reg;
    logic [4:0]  cnt_reg;

    // restoring division, quotient known to fit 32 bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                rem_reg  <= req.dividend;
                dsh_reg  <= 63'(req.divisor) << 31;
                q_reg    <= '0;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg) begin
                if ({1'b0, rem_reg} >= dsh_reg) begin
                    rem_reg <= 62'({1'b0, rem_reg} - dsh_reg);
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else begin
                    q_reg <= {q_reg[30:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

>>> hw/rtl/gqi_core.sv
module gqi_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [23:0]  rate_x,
    input  logic signed [23:0]  rate_y,
    input  logic signed [23:0]  rate_z,
    input  logic                first_sample,
    input  gqi_pkg::cfg_t       cfg,
    input  logic                out_full,
    output logic                ready,
    output gqi_pkg::result_t    res,
    output gqi_pkg::sqrt_req_t  sqrt_req,
    input  gqi_pkg::sqrt_rsp_t  sqrt_rsp,
    output gqi_pkg::div_req_t   div_req,
    input  gqi_pkg::div_rsp_t   div_rsp
);

    typedef enum logic [4:0] {
        S_IDLE, S_VMUL, S_VACC, S_ASHIFT, S_ASQM, S_ASQA, S_ASQRT, S_ASQW,
        S_UMAX, S_UNORM, S_USQM, S_USQA, S_USQRT, S_USQW, S_UDIV, S_UDIVW,
        S_UDONE, S_MOD, S_FOLD1, S_FOLD2, S_CORDIC, S_SCFIX, S_STMUL, S_STACC,
        S_HMUL, S_HACC, S_EMIT
    } state_t;

    typedef enum logic [1:0] {RET_AXIS, RET_SMALL, RET_ORIENT} ret_t;

    state_t state_reg;
    ret_t   ret_reg;

    logic signed [23:0] rate_reg [3];
    logic signed [37:0] v_reg [3];
    logic [36:0]        vm_reg;
    logic [2:0]         sh_reg;
    logic [1:0]         idx_reg;
    logic [63:0]        sum_reg;
    logic [37:0]        a_reg;

    logic signed [37:0] c_reg [4];
    logic               n4_reg;
    logic               quat_reg;
    logic [37:0]        um_reg;
    logic [2:0]         rsh_reg;
    logic [4:0]         lsh_reg;
    logic [31:0]        r_reg;
    logic signed [31:0] uni_reg [4];

    logic [37:0]        t_reg;
    logic [2:0]         k_reg;
    logic               ss_reg;
    logic               sc_reg;
    logic signed [33:0] ct_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic [4:0]         i_reg;
    logic signed [33:0] sn_reg;
    logic signed [33:0] st_reg [4];
    logic [3:0]         jk_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] cur_reg [4];

    logic signed [69:0] prod_reg;
    logic signed [34:0] mul_a;
    logic signed [34:0] mul_b;

    logic [23:0]        rmag;
    logic [54:0]        pround;
    logic [36:0]        pm;
    logic [36:0]        vmag;
    logic [30:0]        vs;
    logic [37:0]        cmag [4];
    logic [37:0]        um_c;
    logic [30:0]        mg;
    logic [1:0]         last_idx;
    logic [37:0]        two_pi_k;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [63:0] term;
    logic signed [63:0] accn;
    logic [1:0]         hj;
    logic [1:0]         hk;

    function automatic logic [37:0] TWO_PI_Q_SHIFT(input logic [2:0] k);
        return gqi_pkg::TWO_PI_Q << k;
    endfunction

    assign hj       = jk_reg[3:2];
    assign hk       = jk_reg[1:0];
    assign last_idx = n4_reg ? 2'd3 : 2'd2;

    always_comb begin
        rmag   = rate_reg[idx_reg][23] ? 24'(-rate_reg[idx_reg]) : 24'(rate_reg[idx_reg]);
        pround = prod_reg[54:0] + 55'd131072;
        pm     = pround[54:18];
        vmag   = v_reg[idx_reg][37] ? 37'(-v_reg[idx_reg]) : 37'(v_reg[idx_reg]);
        vs     = 31'(vmag >> sh_reg);
        um_c   = '0;
        for (int i = 0; i < 4; i++) begin
            cmag[i] = c_reg[i][37] ? 38'(-c_reg[i]) : 38'(c_reg[i]);
            if ((i < 3 || n4_reg) && cmag[i] > um_c) begin
                um_c = cmag[i];
            end
        end
        mg       = 31'((64'(cmag[idx_reg]) >> rsh_reg) << lsh_reg);
        two_pi_k = TWO_PI_Q_SHIFT(k_reg);
        xs       = x_reg >>> i_reg;
        ys       = y_reg >>> i_reg;
        term     = 64'(prod_reg >>> 2);
        accn     = gqi_pkg::ham_neg(hj, hk) ? acc_reg - term : acc_reg + term;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_VMUL:
            begin
                mul_a = 35'(rmag);
                mul_b = 35'(cfg.half_step);
            end
            S_ASQM:
            begin
                mul_a = 35'(vs);
                mul_b = 35'(vs);
            end
            S_USQM:
            begin
                mul_a = 35'(mg);
                mul_b = 35'(mg);
            end
            S_STMUL:
            begin
                mul_a = 35'(uni_reg[idx_reg]);
                mul_b = 35'(sn_reg);
            end
            S_HMUL:
            begin
                mul_a = 35'(cur_reg[hk]);
                mul_b = 35'(st_reg[hj ^ hk]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqrt_req.start    = (state_reg == S_ASQRT) || (state_reg == S_USQRT);
    assign sqrt_req.radicand = sum_reg;
    assign div_req.start     = (state_reg == S_UDIV);
    assign div_req.divisor   = r_reg;
    assign div_req.dividend  = (quat_reg ? (62'(mg) << gqi_pkg::QUAT_FRAC_BITS)
                                         : (62'(mg) << gqi_pkg::ANG_FRAC))
                               + 62'(r_reg >> 1);

    assign ready     = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_EMIT) && !out_full;
    assign res.w     = cur_reg[0];
    assign res.x     = cur_reg[1];
    assign res.y     = cur_reg[2];
    assign res.z     = cur_reg[3];

    always_ff @(posedge clk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_AXIS;
            for (int i = 0; i < 3; i++) begin
                rate_reg[i] <= '0;
                v_reg[i]    <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                c_reg[i]   <= '0;
                uni_reg[i] <= '0;
                st_reg[i]  <= '0;
            end
            cur_reg[0] <= gqi_pkg::QUAT_ONE;
            cur_reg[1] <= '0;
            cur_reg[2] <= '0;
            cur_reg[3] <= '0;
            vm_reg   <= '0;
            sh_reg   <= '0;
            idx_reg  <= '0;
            sum_reg  <= '0;
            a_reg    <= '0;
            n4_reg   <= 1'b0;
            quat_reg <= 1'b0;
            um_reg   <= '0;
            rsh_reg  <= '0;
            lsh_reg  <= '0;
            r_reg    <= '0;
            t_reg    <= '0;
            k_reg    <= '0;
            ss_reg   <= 1'b0;
            sc_reg   <= 1'b0;
            ct_reg   <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            i_reg    <= '0;
            sn_reg   <= '0;
            jk_reg   <= '0;
            acc_reg  <= '0;
        end
        else begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start) begin
                        if (first_sample) begin
                            cur_reg[0] <= cfg.start_w;
                            cur_reg[1] <= cfg.start_x;
                            cur_reg[2] <= cfg.start_y;
                            cur_reg[3] <= cfg.start_z;
                        end
                        if (cfg.half_step != '0) begin
                            rate_reg[0] <= rate_x;
                            rate_reg[1] <= rate_y;
                            rate_reg[2] <= rate_z;
                            idx_reg     <= '0;
                            vm_reg      <= '0;
                            state_reg   <= S_VMUL;
                        end
                    end
                end
                S_VMUL:
                begin
                    state_reg <= S_VACC;
                end
                S_VACC:
                begin
                    v_reg[idx_reg] <= rate_reg[idx_reg][23] ? -38'(pm) : 38'(pm);
                    if (pm > vm_reg) begin
                        vm_reg <= pm;
                    end
                    if (idx_reg == 2'd2) begin
                        sh_reg    <= '0;
                        state_reg <= S_ASHIFT;
                    end
                    else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_VMUL;
                    end
                end
                S_ASHIFT:
                begin
                    if ((vm_reg >> sh_reg) >= 37'(64'd1 << 31)) begin
                        sh_reg <= sh_reg + 3'd1;
                    end
                    else begin
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_ASQM;
                    end
                end
                S_ASQM:
                begin
                    state_reg <= S_ASQA;
                end
                S_ASQA:
                begin
                    sum_reg <= sum_reg + prod_reg[63:0];
                    if (idx_reg == 2'd2) begin
                        state_reg <= S_ASQRT;
                    end
                    else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_ASQM;
                    end
                end
                S_ASQRT:
                begin
                    state_reg <= S_ASQW;
                end
                S_ASQW:
                begin
                    if (sqrt_rsp.done) begin
                        a_reg <= 38'(sqrt_rsp.root) << sh_reg;
                        if ((38'(sqrt_rsp.root) << sh_reg) > gqi_pkg::SMALL_ANGLE) begin
                            c_reg[0] <= v_reg[0];
                            c_reg[1] <= v_reg[1];
                            c_reg[2] <= v_reg[2];
                            c_reg[3] <= '0;
                            n4_reg   <= 1'b0;
                            ret_reg  <= RET_AXIS;
                        end
                        else begin
                            c_reg[0] <= gqi_pkg::ANG_ONE;
                            c_reg[1] <= v_reg[0];
                            c_reg[2] <= v_reg[1];
                            c_reg[3] <= v_reg[2];
                            n4_reg   <= 1'b1;
                            ret_reg  <= RET_SMALL;
                        end
                        quat_reg  <= 1'b0;
                        state_reg <= S_UMAX;
                    end
                end
                // unit-length scaling of c_reg, shared by all three uses
                S_UMAX:
                begin
                    um_reg  <= um_c;
                    rsh_reg <= '0;
                    lsh_reg <= '0;
                    if (um_c == '0) begin
                        for (int i = 0; i < 4; i++) begin
                            uni_reg[i] <= '0;
                        end
                        state_reg <= S_UDONE;
                    end
                    else begin
                        state_reg <= S_UNORM;
                    end
                end
                S_UNORM:
                begin
                    if ((um_reg >> rsh_reg) >= 38'(64'd1 << 31)) begin
                        rsh_reg <= rsh_reg + 3'd1;
                    end
                    else if (rsh_reg == '0 && (64'(um_reg) << lsh_reg) < (64'd1 << 29)) begin
                        lsh_reg <= lsh_reg + 5'd1;
                    end
                    else begin
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_USQM;
                    end
                end
                S_USQM:
                begin
                    state_reg <= S_USQA;
                end
                S_USQA:
                begin
                    sum_reg <= sum_reg + prod_reg[63:0];
                    if (idx_reg == last_idx) begin
                        state_reg <= S_USQRT;
                    end
                    else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_USQM;
                    end
                end
                S_USQRT:
                begin
                    state_reg <= S_USQW;
                end
                S_USQW:
                begin
                    if (sqrt_rsp.done) begin
                        r_reg     <= sqrt_rsp.root;
                        idx_reg   <= '0;
                        state_reg <= S_UDIV;
                    end
                end
                S_UDIV:
                begin
                    state_reg <= S_UDIVW;
                end
                S_UDIVW:
                begin
                    if (div_rsp.done) begin
                        uni_reg[idx_reg] <= c_reg[idx_reg][37] ? -div_rsp.quotient
                                                               : div_rsp.quotient;
                        if (idx_reg == last_idx) begin
                            state_reg <= S_UDONE;
                        end
                        else begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_UDIV;
                        end
                    end
                end
                S_UDONE:
                begin
                    case (ret_reg)
                        RET_AXIS:
                        begin
                            t_reg     <= a_reg;
                            k_reg     <= 3'd5;
                            state_reg <= S_MOD;
                        end
                        RET_SMALL:
                        begin
                            for (int i = 0; i < 4; i++) begin
                                st_reg[i] <= 34'(uni_reg[i]);
                            end
                            jk_reg    <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_HMUL;
                        end
                        RET_ORIENT:
                        begin
                            for (int i = 0; i < 4; i++) begin
                                cur_reg[i] <= uni_reg[i];
                            end
                            state_reg <= S_EMIT;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                // angle modulo 2*pi by scaled compare-subtract
                S_MOD:
                begin
                    if (t_reg >= two_pi_k) begin
                        t_reg <= t_reg - two_pi_k;
                    end
                    if (k_reg == '0) begin
                        state_reg <= S_FOLD1;
                    end
                    else begin
                        k_reg <= k_reg - 3'd1;
                    end
                end
                S_FOLD1:
                begin
                    if (t_reg >= gqi_pkg::PI_Q) begin
                        t_reg  <= t_reg - gqi_pkg::PI_Q;
                        ss_reg <= 1'b1;
                        sc_reg <= 1'b1;
                    end
                    else begin
                        ss_reg <= 1'b0;
                        sc_reg <= 1'b0;
                    end
                    state_reg <= S_FOLD2;
                end
                S_FOLD2:
                begin
                    if (t_reg > gqi_pkg::HALF_PI_Q) begin
                        ct_reg <= 34'(gqi_pkg::PI_Q - t_reg);
                        sc_reg <= ~sc_reg;
                    end
                    else begin
                        ct_reg <= 34'(t_reg);
                    end
                    x_reg     <= gqi_pkg::CORDIC_GAIN;
                    y_reg     <= '0;
                    i_reg     <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (ct_reg >= 0) begin
                        x_reg  <= x_reg - ys;
                        y_reg  <= y_reg + xs;
                        ct_reg <= ct_reg - gqi_pkg::atan_entry(i_reg);
                    end
                    else begin
                        x_reg  <= x_reg + ys;
                        y_reg  <= y_reg - xs;
                        ct_reg <= ct_reg + gqi_pkg::atan_entry(i_reg);
                    end
                    if (i_reg == 5'(gqi_pkg::CORDIC_STEPS - 1)) begin
                        state_reg <= S_SCFIX;
                        idx_reg   <= '0;
                    end
                    else begin
                        i_reg <= i_reg + 5'd1;
                    end
                end
                // quadrant signs on the final CORDIC vector
                S_SCFIX:
                begin
                    sn_reg    <= ss_reg ? -y_reg : y_reg;
                    st_reg[0] <= sc_reg ? -x_reg : x_reg;
                    state_reg <= S_STMUL;
                end
                S_STMUL:
                begin
                    state_reg <= S_STACC;
                end
                S_STACC:
                begin
                    st_reg[idx_reg + 2'd1] <= 34'((prod_reg + 70'sd536870912) >>> 30);
                    if (idx_reg == 2'd2) begin
                        jk_reg    <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_HMUL;
                    end
                    else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_STMUL;
                    end
                end
                S_HMUL:
                begin
                    state_reg <= S_HACC;
                end
                S_HACC:
                begin
                    if (hk == 2'd3) begin
                        c_reg[hj] <= 38'((accn + 64'sd134217728) >>> 28);
                        acc_reg   <= '0;
                    end
                    else begin
                        acc_reg <= accn;
                    end
                    if (jk_reg == 4'd15) begin
                        n4_reg    <= 1'b1;
                        quat_reg  <= 1'b1;
                        ret_reg   <= RET_ORIENT;
                        state_reg <= S_UMAX;
                    end
                    else begin
                        jk_reg    <= jk_reg + 4'd1;
                        state_reg <= S_HMUL;
                    end
                end
                S_EMIT:
                begin
                    if (!out_full) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/gyro_quaternion_integrator.sv
// Channel  | Dir | Payload                                  | Word accepted when
// sample   | in  | rate_x, rate_y, rate_z, first_sample     | sample.valid & sample.ready
// orient   | out | orient_w, orient_x, orient_y, orient_z   | orient.valid & orient.ready
// cfg      | in  | index (0..4), data                       | cfg.valid & cfg.ready
//
// The time a sample that gives a word takes is set mostly by the bit-serial
// square root and divider (up to 3 roots and up to 8 divides); with half step
// time zero a sample gives no word.
// sample.ready is high only while the sequencer is idle; a finished word may
// sit in the output register while the next sample is accepted.
// Reset: identity orientation, default half step time; cfg.ready is always high.
module gyro_quaternion_integrator (
    input  logic          clk,
    input  logic          rst_n,
    gqi_sample_if.sink    sample,
    gqi_orient_if.source  orient,
    gqi_cfg_if.sink       cfg
);

    gqi_pkg::cfg_t      cfg_reg;
    gqi_pkg::result_t   res;
    gqi_pkg::sqrt_req_t sqrt_req;
    gqi_pkg::sqrt_rsp_t sqrt_rsp;
    gqi_pkg::div_req_t  div_req;
    gqi_pkg::div_rsp_t  div_rsp;

    logic               core_ready;
    logic               out_valid_reg;
    logic signed [31:0] ow_reg;
    logic signed [31:0] ox_reg;
    logic signed [31:0] oy_reg;
    logic signed [31:0] oz_reg;

    assign cfg.ready    = 1'b1;
    assign sample.ready = core_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.half_step <= gqi_pkg::HALF_STEP_RESET;
            cfg_reg.start_w   <= gqi_pkg::QUAT_ONE;
            cfg_reg.start_x   <= '0;
            cfg_reg.start_y   <= '0;
            cfg_reg.start_z   <= '0;
        end
        else if (cfg.valid) begin
            case (cfg.index)
                gqi_pkg::REG_HALF_STEP: cfg_reg.half_step <= cfg.data;
                gqi_pkg::REG_START_W:   cfg_reg.start_w   <= cfg.data;
                gqi_pkg::REG_START_X:   cfg_reg.start_x   <= cfg.data;
                gqi_pkg::REG_START_Y:   cfg_reg.start_y   <= cfg.data;
                gqi_pkg::REG_START_Z:   cfg_reg.start_z   <= cfg.data;
                default: ;
            endcase
        end
    end

    gqi_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (sample.valid && core_ready),
        .rate_x       (sample.rate_x),
        .rate_y       (sample.rate_y),
        .rate_z       (sample.rate_z),
        .first_sample (sample.first_sample),
        .cfg          (cfg_reg),
        .out_full     (out_valid_reg),
        .ready        (core_ready),
        .res          (res),
        .sqrt_req     (sqrt_req),
        .sqrt_rsp     (sqrt_rsp),
        .div_req      (div_req),
        .div_rsp      (div_rsp)
    );

    gqi_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    gqi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            ow_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
        end
        else if (res.valid) begin
            out_valid_reg <= 1'b1;
            ow_reg        <= res.w;
            ox_reg        <= res.x;
            oy_reg        <= res.y;
            oz_reg        <= res.z;
        end
        else if (orient.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign orient.valid    = out_valid_reg;
    assign orient.orient_w = ow_reg;
    assign orient.orient_x = ox_reg;
    assign orient.orient_y = oy_reg;
    assign orient.orient_z = oz_reg;

endmodule
